// File: design/rbg_pkg.sv
// shared constants, controller/datapath handshake structs and the weight table builder
// for the reply burst grouper; no dependencies
package rbg_pkg;

    localparam int DEF_TABLE_SLOTS      = 32;
    localparam int DEF_WEIGHT_FRAC_BITS = 20;

    localparam int ADDR_W      = 24;
    localparam int TIME_W      = 48;
    localparam int LEVEL_W     = 12;
    localparam int COUNT_W     = 10;
    localparam int OFFSET_W    = 24;
    localparam int LEVEL_STEPS = 1601;
    localparam int LEVEL_IDX_W = 11;
    localparam int TAB_W       = 32;
    localparam int QBITS       = 60;
    localparam int SERIES_TERMS = 30 + 4;
    localparam int DB_DECADE   = 320;

    localparam logic [ADDR_W-1:0]         GAP_RESET = 24'd50000;
    localparam logic [COUNT_W-1:0]        COUNT_MAX = 10'd1023;
    localparam logic [OFFSET_W-1:0]       OFFSET_MAX = 24'hFFFFFF;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -12'sd1600;
    localparam logic [63:0]               QONE = 64'd1 << QBITS;

    localparam logic KIND_GROUP = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

    typedef logic [TAB_W-1:0] wtab_t [LEVEL_STEPS];

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_eval;
        logic cent_wr;
        logic idx_inc;
        logic pick_init;
        logic pick_rd;
        logic pick_cmp;
        logic out_rd;
        logic out_group;
        logic ins_rd;
        logic ins_off;
        logic ins_prod;
        logic ins_wr;
        logic ins_new;
        logic out_drop;
    } cmd_t;

    typedef struct packed {
        logic closes;
        logic idx_last;
        logic div_done;
        logic any_closed;
        logic more_closed;
        logic out_busy;
        logic match_found;
        logic free_found;
    } status_t;

    // shift-subtract divide, evaluated at elaboration only
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[QBITS+63:QBITS];
    endfunction

    function automatic logic [63:0] atanh_inv(logic [63:0] m);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] odd;
        logic [63:0] mm;
        p   = udiv64(QONE, m);
        sum = '0;
        odd = 64'd1;
        mm  = m * m;
        while (p != 64'd0)
        begin
            sum = sum + udiv64(p, odd);
            p   = udiv64(p, mm);
            odd = odd + 64'd2;
        end
        return sum;
    endfunction

    // weight per attenuation step of 1/16 dB, rounded to wfb fraction bits
    function automatic wtab_t weight_table(int wfb);
        wtab_t       tab;
        logic [63:0] ln10;
        logic [63:0] step;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] a;
        int          q;
        int          shift;
        ln10  = 64'd6 * atanh_inv(64'd3) + 64'd2 * atanh_inv(64'd9);
        step  = udiv64(ln10, 64'(DB_DECADE));
        shift = QBITS - wfb;
        for (int idx = 0; idx < LEVEL_STEPS; idx++)
        begin
            a = 64'(idx);
            q = 0;
            while (a >= 64'(DB_DECADE))
            begin
                a = a - 64'(DB_DECADE);
                q = q + 1;
            end
            t    = step * a;
            term = QONE;
            sum  = QONE;
            for (int k = 1; k <= SERIES_TERMS; k++)
            begin
                term = udiv64(qmul(term, t), 64'(k));
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            for (int j = 0; j < q; j++)
                sum = udiv64(sum, 64'd10);
            tab[idx] = TAB_W'((sum + (64'd1 << (shift - 1))) >> shift);
        end
        return tab;
    endfunction

endpackage

// File: design/reply_burst_grouper_core.sv
// Reply burst grouper: replies enter on the in channel while in_stall is low and are taken
// one at a time. Each reply is scanned against every table slot through the single read
// port of the slot memory, runs the bit-serial divider for each group it closes and an
// ordering scan for each group emitted, then updates or opens a slot for the reply; each
// emitted word can wait on out_stall. Closed groups come out in ascending centroid order,
// a full table gives a drop word, and last marks the final word a reply causes. burst_gap
// is to be written through cfg_write/cfg_data only while the block is idle; the block
// itself does not enforce it.
// depends on rbg_pkg, rbg_ctrl, rbg_datapath
module reply_burst_grouper_core import rbg_pkg::*; #(
    parameter int TABLE_SLOTS      = DEF_TABLE_SLOTS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [ADDR_W-1:0]         cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [ADDR_W-1:0]         icao,
    input  logic [TIME_W-1:0]         arrival_time,
    input  logic signed [LEVEL_W-1:0] signal_level,
    input  logic                      signal_valid,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      kind,
    output logic [ADDR_W-1:0]         burst_icao,
    output logic [TIME_W-1:0]         trigger_us,
    output logic [TIME_W-1:0]         centroid_us,
    output logic signed [LEVEL_W-1:0] peak_dbfs,
    output logic                      peak_valid,
    output logic [COUNT_W-1:0]        reply_total,
    output logic                      last
);

    cmd_t    cmd;
    status_t st;

    rbg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    rbg_datapath #(
        .TABLE_SLOTS      (TABLE_SLOTS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .icao         (icao),
        .arrival_time (arrival_time),
        .signal_level (signal_level),
        .signal_valid (signal_valid),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .burst_icao   (burst_icao),
        .trigger_us   (trigger_us),
        .centroid_us  (centroid_us),
        .peak_dbfs    (peak_dbfs),
        .peak_valid   (peak_valid),
        .reply_total  (reply_total),
        .last         (last)
    );

endmodule

// File: design/rbg_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// File: design/rbg_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
module rbg_div #(
    parameter int N_W = 55,
    parameter int D_W = 31
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;
    logic [N_W-1:0]   quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     trial;

    assign trial = {rem_reg, quo_reg[N_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(N_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            div_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= D_W'(trial - {1'b0, div_reg});
                quo_reg <= {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[D_W-1:0];
                quo_reg <= {quo_reg[N_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: design/rbg_ctrl.sv
// sequencer for the reply burst grouper: scan, close, order, emit, insert
// depends on rbg_pkg
module rbg_ctrl import rbg_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_EV, S_DIV, S_CENT_WR, S_PICK_INIT, S_PICK_RD,
        S_PICK_CMP, S_OUT_RD, S_OUT_LOAD, S_INSERT, S_INS_RD, S_INS_OFF,
        S_INS_PROD, S_INS_WR, S_INS_NEW, S_DROP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                if (st.closes)
                    state_next = S_DIV;
                else if (st.idx_last)
                    state_next = S_PICK_INIT;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                    state_next = S_CENT_WR;
            end
            S_CENT_WR:
            begin
                cmd.cent_wr = 1'b1;
                if (st.idx_last)
                    state_next = S_PICK_INIT;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_PICK_INIT:
            begin
                cmd.pick_init = 1'b1;
                state_next    = st.any_closed ? S_PICK_RD : S_INSERT;
            end
            S_PICK_RD:
            begin
                cmd.pick_rd = 1'b1;
                state_next  = S_PICK_CMP;
            end
            S_PICK_CMP:
            begin
                cmd.pick_cmp = 1'b1;
                if (st.idx_last)
                    state_next = S_OUT_RD;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_PICK_RD;
                end
            end
            S_OUT_RD:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_rd = 1'b1;
                    state_next = S_OUT_LOAD;
                end
            end
            S_OUT_LOAD:
            begin
                cmd.out_group = 1'b1;
                state_next    = st.more_closed ? S_PICK_INIT : S_INSERT;
            end
            S_INSERT:
            begin
                if (st.match_found)
                    state_next = S_INS_RD;
                else if (st.free_found)
                    state_next = S_INS_NEW;
                else
                    state_next = S_DROP;
            end
            S_INS_RD:
            begin
                cmd.ins_rd = 1'b1;
                state_next = S_INS_OFF;
            end
            S_INS_OFF:
            begin
                cmd.ins_off = 1'b1;
                state_next  = S_INS_PROD;
            end
            S_INS_PROD:
            begin
                cmd.ins_prod = 1'b1;
                state_next   = S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_INS_NEW:
            begin
                cmd.ins_new = 1'b1;
                state_next  = S_IDLE;
            end
            S_DROP:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_drop = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = stall_reg;

endmodule

// File: design/rbg_datapath.sv
// slot table, centroid store, divider, ordering and output word registers
// depends on rbg_pkg, rbg_ram and rbg_div
module rbg_datapath import rbg_pkg::*; #(
    parameter int TABLE_SLOTS      = DEF_TABLE_SLOTS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   st,
    input  logic                      cfg_write,
    input  logic [ADDR_W-1:0]         cfg_data,
    input  logic [ADDR_W-1:0]         icao,
    input  logic [TIME_W-1:0]         arrival_time,
    input  logic signed [LEVEL_W-1:0] signal_level,
    input  logic                      signal_valid,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      kind,
    output logic [ADDR_W-1:0]         burst_icao,
    output logic [TIME_W-1:0]         trigger_us,
    output logic [TIME_W-1:0]         centroid_us,
    output logic signed [LEVEL_W-1:0] peak_dbfs,
    output logic                      peak_valid,
    output logic [COUNT_W-1:0]        reply_total,
    output logic                      last
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int WGT_W   = WEIGHT_FRAC_BITS + 1;
    localparam int WSUM_W  = WEIGHT_FRAC_BITS + 11;
    localparam int OSUM_W  = WEIGHT_FRAC_BITS + 35;
    localparam int PROD_W  = WGT_W + OFFSET_W;
    localparam int ENTRY_W = ADDR_W + 2 * TIME_W + COUNT_W + WSUM_W + OSUM_W + LEVEL_W + 1;
    localparam wtab_t WTAB = weight_table(WEIGHT_FRAC_BITS);

    logic [ADDR_W-1:0]         gap_reg;
    logic [ADDR_W-1:0]         icao_reg;
    logic [TIME_W-1:0]         arr_reg;
    logic signed [LEVEL_W-1:0] lvl_reg;
    logic                      sv_reg;
    logic [WGT_W-1:0]          weight_reg;

    logic [TABLE_SLOTS-1:0] used_reg;
    logic [TABLE_SLOTS-1:0] closed_reg;
    logic [SLOT_W-1:0]      idx_reg;
    logic [SLOT_W-1:0]      match_idx_reg;
    logic                   match_found_reg;
    logic [SLOT_W-1:0]      free_idx_reg;
    logic                   free_found_reg;
    logic [SLOT_W-1:0]      best_idx_reg;
    logic [TIME_W-1:0]      best_cent_reg;
    logic                   best_found_reg;

    logic                   wzero_reg;
    logic [TIME_W-1:0]      first_reg;
    logic [TIME_W-1:0]      last_reg;
    logic [ENTRY_W-1:0]     entry_reg;
    logic [OFFSET_W-1:0]    off_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic                      out_valid_reg;
    logic                      kind_reg;
    logic [ADDR_W-1:0]         icao_out_reg;
    logic [TIME_W-1:0]         trig_reg;
    logic [TIME_W-1:0]         cent_out_reg;
    logic signed [LEVEL_W-1:0] peak_out_reg;
    logic                      pv_out_reg;
    logic [COUNT_W-1:0]        total_reg;
    logic                      last_reg_out;

    logic                      ram_re;
    logic [SLOT_W-1:0]         ram_raddr;
    logic                      ram_we;
    logic [SLOT_W-1:0]         ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [ENTRY_W-1:0]        ram_rdata;
    logic [TIME_W-1:0]         cent_rdata;
    logic [TIME_W-1:0]         cent_wdata;

    logic [ADDR_W-1:0]         e_addr;
    logic [TIME_W-1:0]         e_first;
    logic [TIME_W-1:0]         e_last;
    logic [COUNT_W-1:0]        e_count;
    logic [WSUM_W-1:0]         e_wsum;
    logic [OSUM_W-1:0]         e_osum;
    logic signed [LEVEL_W-1:0] e_peak;
    logic                      e_pv;

    logic [ADDR_W-1:0]         u_addr;
    logic [TIME_W-1:0]         u_first;
    logic [TIME_W-1:0]         u_last;
    logic [COUNT_W-1:0]        u_count;
    logic [WSUM_W-1:0]         u_wsum;
    logic [OSUM_W-1:0]         u_osum;
    logic signed [LEVEL_W-1:0] u_peak;
    logic                      u_pv;

    logic signed [LEVEL_W-1:0] lvl_clamp;
    logic [LEVEL_W-1:0]        lvl_neg;
    logic [TIME_W-1:0]         d_last;
    logic [TIME_W-1:0]         d_first;
    logic                      closes;
    logic                      div_start;
    logic                      div_busy;
    logic                      div_done;
    logic [OSUM_W-1:0]         div_quo;
    logic [TABLE_SLOTS-1:0]    rest_closed;
    logic                      upd_peak;
    logic [COUNT_W-1:0]        n_count;
    logic [WSUM_W-1:0]         n_wsum;
    logic [OSUM_W-1:0]         n_osum;
    logic signed [LEVEL_W-1:0] n_peak;
    logic                      n_pv;

    assign {e_addr, e_first, e_last, e_count, e_wsum, e_osum, e_peak, e_pv} = ram_rdata;
    assign {u_addr, u_first, u_last, u_count, u_wsum, u_osum, u_peak, u_pv} = entry_reg;

    always_comb
    begin
        if (signal_level < LEVEL_MIN)
            lvl_clamp = LEVEL_MIN;
        else if (signal_level > 12'sd0)
            lvl_clamp = '0;
        else
            lvl_clamp = signal_level;
    end
    assign lvl_neg = LEVEL_W'(-lvl_clamp);

    assign d_last  = arr_reg - e_last;
    assign d_first = arr_reg - e_first;
    assign closes  = used_reg[idx_reg] && !d_last[TIME_W-1] && (d_last > TIME_W'(gap_reg));
    assign div_start   = cmd.scan_eval && closes;
    assign rest_closed = closed_reg & ~(TABLE_SLOTS'(1) << best_idx_reg);

    // read port shared by scan, emit and update
    always_comb
    begin
        ram_re    = cmd.scan_rd || cmd.out_rd || cmd.ins_rd;
        ram_raddr = idx_reg;
        if (cmd.out_rd)
            ram_raddr = best_idx_reg;
        else if (cmd.ins_rd)
            ram_raddr = match_idx_reg;
    end

    always_comb
    begin
        upd_peak = sv_reg && (!u_pv || (lvl_reg > u_peak));
        n_peak   = upd_peak ? lvl_reg : u_peak;
        n_pv     = u_pv || sv_reg;
        if (u_count < COUNT_MAX)
        begin
            n_count = u_count + COUNT_W'(1);
            n_wsum  = u_wsum + WSUM_W'(weight_reg);
            n_osum  = u_osum + OSUM_W'(prod_reg);
        end
        else
        begin
            n_count = u_count;
            n_wsum  = u_wsum;
            n_osum  = u_osum;
        end
    end

    always_comb
    begin
        ram_we    = cmd.ins_wr || cmd.ins_new;
        ram_waddr = cmd.ins_new ? free_idx_reg : match_idx_reg;
        if (cmd.ins_new)
            ram_wdata = {icao_reg, arr_reg, arr_reg, COUNT_W'(1), WSUM_W'(weight_reg),
                         OSUM_W'(0), (sv_reg ? lvl_reg : LEVEL_W'(0)), sv_reg};
        else
            ram_wdata = {u_addr, u_first, arr_reg, n_count, n_wsum, n_osum, n_peak, n_pv};
    end

    assign cent_wdata = wzero_reg ? last_reg : (first_reg + div_quo[TIME_W-1:0]);

    rbg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rbg_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TABLE_SLOTS)
    ) u_cent_ram (
        .clk   (clk),
        .we    (cmd.cent_wr),
        .waddr (idx_reg),
        .wdata (cent_wdata),
        .re    (cmd.pick_rd),
        .raddr (idx_reg),
        .rdata (cent_rdata)
    );

    rbg_div #(
        .N_W (OSUM_W),
        .D_W (WSUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (e_osum),
        .divisor  (e_wsum),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg         <= GAP_RESET;
            used_reg        <= '0;
            closed_reg      <= '0;
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                gap_reg <= cfg_data;
            if (cmd.load || cmd.pick_init)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + SLOT_W'(1);
            if (cmd.load)
            begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            if (cmd.scan_eval)
            begin
                if (closes)
                begin
                    closed_reg[idx_reg] <= 1'b1;
                    used_reg[idx_reg]   <= 1'b0;
                end
                if (used_reg[idx_reg] && !closes && e_addr == icao_reg && !match_found_reg)
                    match_found_reg <= 1'b1;
                if ((!used_reg[idx_reg] || closes) && !free_found_reg)
                    free_found_reg <= 1'b1;
            end
            if (cmd.pick_init)
                best_found_reg <= 1'b0;
            else if (cmd.pick_cmp && closed_reg[idx_reg]
                     && (!best_found_reg || cent_rdata < best_cent_reg))
                best_found_reg <= 1'b1;
            if (cmd.out_group)
                closed_reg[best_idx_reg] <= 1'b0;
            if (cmd.ins_new)
                used_reg[free_idx_reg] <= 1'b1;
            if (cmd.out_group || cmd.out_drop)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            icao_reg   <= icao;
            arr_reg    <= arrival_time;
            lvl_reg    <= lvl_clamp;
            sv_reg     <= signal_valid;
            weight_reg <= signal_valid ? WTAB[lvl_neg[LEVEL_IDX_W-1:0]][WGT_W-1:0]
                                       : (WGT_W'(1) << WEIGHT_FRAC_BITS);
        end
        if (cmd.scan_eval)
        begin
            if (used_reg[idx_reg] && !closes && e_addr == icao_reg && !match_found_reg)
                match_idx_reg <= idx_reg;
            if ((!used_reg[idx_reg] || closes) && !free_found_reg)
                free_idx_reg <= idx_reg;
            if (closes)
            begin
                wzero_reg <= (e_wsum == '0);
                first_reg <= e_first;
                last_reg  <= e_last;
            end
        end
        if (cmd.pick_cmp && closed_reg[idx_reg]
            && (!best_found_reg || cent_rdata < best_cent_reg))
        begin
            best_idx_reg  <= idx_reg;
            best_cent_reg <= cent_rdata;
        end
        if (cmd.ins_off)
        begin
            entry_reg <= ram_rdata;
            if (d_first[TIME_W-1])
                off_reg <= '0;
            else if (d_first > TIME_W'(OFFSET_MAX))
                off_reg <= OFFSET_MAX;
            else
                off_reg <= d_first[OFFSET_W-1:0];
        end
        if (cmd.ins_prod)
            prod_reg <= PROD_W'(weight_reg) * PROD_W'(off_reg);
        if (cmd.out_group)
        begin
            kind_reg     <= KIND_GROUP;
            icao_out_reg <= e_addr;
            trig_reg     <= arr_reg;
            cent_out_reg <= best_cent_reg;
            peak_out_reg <= e_pv ? e_peak : LEVEL_W'(0);
            pv_out_reg   <= e_pv;
            total_reg    <= e_count;
            last_reg_out <= !(|rest_closed) && (match_found_reg || free_found_reg);
        end
        else if (cmd.out_drop)
        begin
            kind_reg     <= KIND_DROP;
            icao_out_reg <= icao_reg;
            trig_reg     <= arr_reg;
            cent_out_reg <= arr_reg;
            peak_out_reg <= sv_reg ? lvl_reg : LEVEL_W'(0);
            pv_out_reg   <= sv_reg;
            total_reg    <= COUNT_W'(1);
            last_reg_out <= 1'b1;
        end
    end

    // ram data for the entry under scan would be dropped here, so u_first path uses entry_reg;
    // d_first is evaluated against ram data during ins_off
    assign st.closes      = closes;
    assign st.idx_last    = (idx_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign st.div_done    = div_done;
    assign st.any_closed  = |closed_reg;
    assign st.more_closed = |rest_closed;
    assign st.out_busy    = out_valid_reg;
    assign st.match_found = match_found_reg;
    assign st.free_found  = free_found_reg;

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign burst_icao  = icao_out_reg;
    assign trigger_us  = trig_reg;
    assign centroid_us = cent_out_reg;
    assign peak_dbfs   = peak_out_reg;
    assign peak_valid  = pv_out_reg;
    assign reply_total = total_reg;
    assign last        = last_reg_out;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_group || cmd.out_drop) |-> !out_valid_reg)
        else $error("output word loaded while previous word pending");

    a_used_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !(|(used_reg & closed_reg)))
        else $error("slot both open and awaiting emission");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_new_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_new |-> !used_reg[free_idx_reg] && free_found_reg)
        else $error("new group placed in an occupied slot");

endmodule
